// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the region selector.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ncrs_pkg.sv =====
// Shared types and constants for the nearest-centre region selector.
// No dependencies.
`timescale 1ns / 1ps

package ncrs_pkg;

	localparam int KEEP_SLOTS_DEF = 8;
	localparam int COORD_BITS_DEF = 12;

	localparam int ACTION_W   = 2;
	localparam int DIM_W      = 13;
	localparam int AREA_W     = 25;
	localparam int MAXREG_W   = 4;
	localparam int CENTER_W   = DIM_W - 1;
	localparam int RANK_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = AREA_W;
	localparam int M_FIELDS_W = 2 + RANK_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	localparam logic [AREA_W-1:0]   MIN_AREA_RST     = AREA_W'(0);
	localparam logic [MAXREG_W-1:0] MAX_REGIONS_RST  = MAXREG_W'(3);
	localparam logic [DIM_W-1:0]    IMAGE_WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0]    IMAGE_HEIGHT_RST = DIM_W'(480);

	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_OFFER = 2'd1,
		ACT_QUERY = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_AREA     = 2'd0,
		CFG_MAX_REGIONS  = 2'd1,
		CFG_IMAGE_WIDTH  = 2'd2,
		CFG_IMAGE_HEIGHT = 2'd3
	} cfg_reg_t;

endpackage

// ===== hw/rtl/nearest_center_region_select.sv =====
// Nearest-centre region selector: filters region descriptors and keeps the
// ones nearest the image centre; answers label queries. Uses ncrs_pkg.
// Pipeline: input register, then distance register, then result register (m_tvalid).
// Throughput: one item per cycle while m_tready does not stall the output; the store compare needs no extra stage.
// Reset: store emptied, registers to min_area 0, max_regions 3, 640 x 480.
// Payload and entry storage are not reset; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nearest_center_region_select #(
	parameter int KEEP_SLOTS = ncrs_pkg::KEEP_SLOTS_DEF,
	parameter int COORD_BITS = ncrs_pkg::COORD_BITS_DEF,
	localparam int S_TDATA_W = ((5 * COORD_BITS + 2 * ncrs_pkg::DIM_W
		+ ncrs_pkg::AREA_W + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [ncrs_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [ncrs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// label, box_left, box_top, box_width, box_height, region_area,
	// centroid_col, centroid_row
	input  logic [S_TDATA_W-1:0]              s_tdata,
	// action
	input  logic [ncrs_pkg::ACTION_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// accepted, is_kept, rank
	output logic [ncrs_pkg::M_TDATA_W-1:0]    m_tdata
);
	import ncrs_pkg::*;

	localparam int DIFF_W  = (COORD_BITS > CENTER_W) ? COORD_BITS : CENTER_W;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int DIST_W  = SQ_W + 1;
	localparam int KEY_W   = DIST_W + COORD_BITS;
	localparam int SUM_W   = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;
	localparam int CNT_W   = $clog2(KEEP_SLOTS + 2);
	localparam int CMP_W   = (CNT_W > MAXREG_W) ? CNT_W : MAXREG_W;
	localparam int RCNT_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;
	localparam int IN_W    = 5 * COORD_BITS + 2 * DIM_W + AREA_W;
	localparam int OFS_LFT = COORD_BITS;
	localparam int OFS_TOP = 2 * COORD_BITS;
	localparam int OFS_BW  = 3 * COORD_BITS;
	localparam int OFS_BH  = OFS_BW + DIM_W;
	localparam int OFS_AR  = OFS_BH + DIM_W;
	localparam int OFS_CC  = OFS_AR + AREA_W;
	localparam int OFS_CR  = OFS_CC + COORD_BITS;

	// configuration
	logic [AREA_W-1:0]   min_area_q;
	logic [MAXREG_W-1:0] max_regions_q;
	logic [DIM_W-1:0]    image_width_q;
	logic [DIM_W-1:0]    image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_area_q     <= MIN_AREA_RST;
			max_regions_q  <= MAX_REGIONS_RST;
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_MIN_AREA:     min_area_q     <= cfg_wdata[AREA_W-1:0];
				CFG_MAX_REGIONS:  max_regions_q  <= cfg_wdata[MAXREG_W-1:0];
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata[DIM_W-1:0];
			endcase
		end
	end

	// handshake
	logic valid_s1, valid_s2, m_valid_q;
	logic out_ready, s2_free, s1_free, adv_s1, adv_s2, fire_in;

	assign out_ready = !m_valid_q || m_tready;
	assign adv_s2    = valid_s2 && out_ready;
	assign s2_free   = !valid_s2 || out_ready;
	assign adv_s1    = valid_s1 && s2_free;
	assign s1_free   = !valid_s1 || s2_free;
	assign s_tready  = s1_free;
	assign fire_in   = s_tvalid && s1_free;
	assign m_tvalid  = m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= s_tvalid;
			if (s2_free)
				valid_s2 <= valid_s1;
			if (out_ready)
				m_valid_q <= valid_s2;
		end
	end

	// stage 1: registered item
	action_t                 action_s1;
	logic [COORD_BITS-1:0]   label_s1, left_s1, top_s1, cc_s1, cr_s1;
	logic [DIM_W-1:0]        bw_s1, bh_s1;
	logic [AREA_W-1:0]       area_s1;

	always_ff @(posedge clk) begin
		if (fire_in) begin
			action_s1 <= action_t'(s_tuser);
			label_s1  <= s_tdata[OFS_LFT-1:0];
			left_s1   <= s_tdata[OFS_TOP-1:OFS_LFT];
			top_s1    <= s_tdata[OFS_BW-1:OFS_TOP];
			bw_s1     <= s_tdata[OFS_BH-1:OFS_BW];
			bh_s1     <= s_tdata[OFS_AR-1:OFS_BH];
			area_s1   <= s_tdata[OFS_CC-1:OFS_AR];
			cc_s1     <= s_tdata[OFS_CR-1:OFS_CC];
			cr_s1     <= s_tdata[IN_W-1:OFS_CR];
		end
	end

	// distance and border / area filter
	logic [DIFF_W-1:0] ctr_x, ctr_y, pos_x, pos_y, dx, dy;
	logic [SQ_W-1:0]   sq_x, sq_y;
	logic [DIST_W-1:0] dist_s1;
	logic              touch_s1, pass_s1;

	always_comb begin
		ctr_x    = DIFF_W'(image_width_q[DIM_W-1:1]);
		ctr_y    = DIFF_W'(image_height_q[DIM_W-1:1]);
		pos_x    = DIFF_W'(cc_s1);
		pos_y    = DIFF_W'(cr_s1);
		dx       = (pos_x > ctr_x) ? pos_x - ctr_x : ctr_x - pos_x;
		dy       = (pos_y > ctr_y) ? pos_y - ctr_y : ctr_y - pos_y;
		sq_x     = SQ_W'(dx) * SQ_W'(dx);
		sq_y     = SQ_W'(dy) * SQ_W'(dy);
		dist_s1  = DIST_W'(sq_x) + DIST_W'(sq_y);
		touch_s1 = (left_s1 == '0) || (top_s1 == '0)
			|| (SUM_W'(left_s1) + SUM_W'(bw_s1) >= SUM_W'(image_width_q))
			|| (SUM_W'(top_s1) + SUM_W'(bh_s1) >= SUM_W'(image_height_q));
		pass_s1  = !touch_s1 && (area_s1 >= min_area_q);
	end

	// stage 2
	action_t               action_s2;
	logic [COORD_BITS-1:0] label_s2;
	logic [DIST_W-1:0]     dist_s2;
	logic                  pass_s2;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			action_s2 <= action_s1;
			label_s2  <= label_s1;
			dist_s2   <= dist_s1;
			pass_s2   <= pass_s1;
		end
	end

	// kept set
	logic [KEEP_SLOTS-1:0] valid_q;
	logic [DIST_W-1:0]     dist_q  [KEEP_SLOTS];
	logic [COORD_BITS-1:0] label_q [KEEP_SLOTS];

	logic [KEY_W-1:0]      elem_key   [KEEP_SLOTS+1];
	logic [KEEP_SLOTS:0]   elem_valid;
	logic [CNT_W-1:0]      smaller    [KEEP_SLOTS+1];
	logic [KEEP_SLOTS:0]   keep;
	logic [KEEP_SLOTS-1:0] match, free_slot, first_free, valid_next;
	logic [KEY_W-1:0]      q_key;
	logic [RCNT_W-1:0]     rank_cnt;
	logic                  found, offer_ok, res_accepted, res_kept;
	logic [RANK_W-1:0]     res_rank;

	always_comb begin
		for (int i = 0; i < KEEP_SLOTS; i++) begin
			elem_key[i]   = {dist_q[i], label_q[i]};
			elem_valid[i] = valid_q[i];
			match[i]      = valid_q[i] && (label_q[i] == label_s2);
		end
		found    = |match;
		offer_ok = (action_s2 == ACT_OFFER) && (label_s2 != '0) && !found && pass_s2;
		elem_key[KEEP_SLOTS]   = {dist_s2, label_s2};
		elem_valid[KEEP_SLOTS] = offer_ok;

		// an element survives when fewer than the limit lie below it
		for (int j = 0; j <= KEEP_SLOTS; j++) begin
			smaller[j] = '0;
			for (int i = 0; i <= KEEP_SLOTS; i++)
				if (elem_valid[i] && (elem_key[i] < elem_key[j]))
					smaller[j] = smaller[j] + CNT_W'(1);
			keep[j] = elem_valid[j] && (CMP_W'(smaller[j]) < CMP_W'(max_regions_q))
				&& (smaller[j] < CNT_W'(KEEP_SLOTS));
		end

		free_slot  = ~keep[KEEP_SLOTS-1:0];
		first_free = free_slot & (~free_slot + KEEP_SLOTS'(1));
		valid_next = keep[KEEP_SLOTS-1:0] | (keep[KEEP_SLOTS] ? first_free : '0);

		q_key = '0;
		for (int i = 0; i < KEEP_SLOTS; i++)
			if (match[i])
				q_key = q_key | elem_key[i];
		rank_cnt = '0;
		for (int i = 0; i < KEEP_SLOTS; i++)
			if (valid_q[i] && (elem_key[i] > q_key))
				rank_cnt = rank_cnt + RCNT_W'(1);

		res_accepted = 1'b0;
		res_kept     = 1'b0;
		res_rank     = '0;
		unique case (action_s2)
			ACT_OFFER: res_accepted = keep[KEEP_SLOTS];
			ACT_QUERY: begin
				res_kept = found && (label_s2 != '0);
				res_rank = res_kept ? rank_cnt[RANK_W-1:0] : '0;
			end
			ACT_CLEAR: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv_s2) begin
			if (action_s2 == ACT_CLEAR)
				valid_q <= '0;
			else if (offer_ok)
				valid_q <= valid_next;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < KEEP_SLOTS; i++) begin
			if (adv_s2 && keep[KEEP_SLOTS] && first_free[i]) begin
				dist_q[i]  <= dist_s2;
				label_q[i] <= label_s2;
			end
		end
	end

	// result register
	logic              acc_q, kept_q;
	logic [RANK_W-1:0] rank_q;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			acc_q  <= res_accepted;
			kept_q <= res_kept;
			rank_q <= res_rank;
		end
	end

	assign m_tdata = {(M_TDATA_W - M_FIELDS_W)'(0), rank_q, kept_q, acc_q};

	`ASSERT_ALWAYS(a_store_grows_by_one, $countones(valid_q) <= $countones($past(valid_q)) + 1, "store grew by more than one entry")
	`ASSERT_NEXT(a_clear_empties, adv_s2 && (action_s2 == ACT_CLEAR), valid_q == '0, "store not empty after clear")
	`ASSERT_NEXT(a_accept_stored, adv_s2 && res_accepted, valid_q != '0, "accepted region not stored")
	`ASSERT_NEXT(a_store_idle, !adv_s2, $stable(valid_q), "store changed without an item")

endmodule

// ===== dv/tb_nearest_center_region_select.sv =====
// Self-checking testbench for nearest_center_region_select: streams region offers,
// label queries and clears through the item ports and predicts every result.
// Depends on ncrs_pkg and the nearest_center_region_select RTL.
`timescale 1ns / 1ps

module tb_nearest_center_region_select;
	import ncrs_pkg::*;

	localparam int KEEP = KEEP_SLOTS_DEF;
	localparam int CB = COORD_BITS_DEF;
	localparam int S_TDATA_W = ((5 * CB + 2 * DIM_W + AREA_W + 7) / 8) * 8;
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
	localparam int unsigned AREA_TOP = 16777216;
	localparam int unsigned COORD_TOP = 4095;
	localparam int unsigned DIM_TOP = 4096;

	typedef struct {
		logic [ACTION_W-1:0] act;
		logic [CB-1:0]       label;
		logic [CB-1:0]       box_left;
		logic [CB-1:0]       box_top;
		logic [DIM_W-1:0]    box_width;
		logic [DIM_W-1:0]    box_height;
		logic [AREA_W-1:0]   region_area;
		logic [CB-1:0]       centroid_col;
		logic [CB-1:0]       centroid_row;
	} region_item_t;

	typedef struct {
		logic              accepted;
		logic              is_kept;
		logic [RANK_W-1:0] rank;
	} select_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// label, box_left, box_top, box_width, box_height, region_area,
	// centroid_col, centroid_row
	logic [S_TDATA_W-1:0] s_tdata = '0;
	// action
	logic [ACTION_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// accepted, is_kept, rank
	logic [M_TDATA_W-1:0] m_tdata;

	// predicted block state and registers
	longint unsigned   kept_dist [KEEP];
	logic [CB-1:0]     kept_label [KEEP];
	bit                kept_valid [KEEP];
	logic [AREA_W-1:0]   min_area_r = MIN_AREA_RST;
	logic [MAXREG_W-1:0] max_regions_r = MAX_REGIONS_RST;
	logic [DIM_W-1:0]    width_r = IMAGE_WIDTH_RST;
	logic [DIM_W-1:0]    height_r = IMAGE_HEIGHT_RST;

	region_item_t   pending_q[$];
	select_result_t answer_q[$];
	region_item_t   cur_item;

	int src_gap = 0;
	int snk_wait = 0;
	int snk_hold = 0;
	bit src_quiet = 0;
	bit snk_quiet = 0;
	int label_span = 12;
	int fail_count = 0;
	int n_results = 0;
	int n_entered = 0;
	int n_hits = 0;
	int n_settings = 0;

	nearest_center_region_select u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic void clear_kept();
		for (int i = 0; i < KEEP; i++) begin
			kept_dist[i] = 0;
			kept_label[i] = '0;
			kept_valid[i] = 0;
		end
	endfunction

	function automatic int find_kept(logic [CB-1:0] lab);
		for (int i = 0; i < KEEP; i++)
			if (kept_valid[i] && kept_label[i] == lab)
				return i;
		return -1;
	endfunction

	function automatic bit pair_above(longint unsigned da, logic [CB-1:0] la,
			longint unsigned db, logic [CB-1:0] lb);
		return (da > db) || (da == db && la > lb);
	endfunction

	function automatic bit offer_region(region_item_t it);
		longint unsigned cd [KEEP + 1];
		logic [CB-1:0] cl [KEEP + 1];
		longint unsigned dx, dy, cx0, cy0, cap;
		int n, worst;
		bit in_set;
		n = 0;
		in_set = 1;
		if (it.label == 0 || find_kept(it.label) >= 0)
			return 0;
		if (it.box_left == 0 || it.box_top == 0 ||
				64'(it.box_left) + 64'(it.box_width) >= 64'(width_r) ||
				64'(it.box_top) + 64'(it.box_height) >= 64'(height_r))
			return 0;
		if (it.region_area < min_area_r)
			return 0;
		cx0 = 64'(width_r) / 2;
		cy0 = 64'(height_r) / 2;
		dx = (64'(it.centroid_col) > cx0) ? 64'(it.centroid_col) - cx0 : cx0 - 64'(it.centroid_col);
		dy = (64'(it.centroid_row) > cy0) ? 64'(it.centroid_row) - cy0 : cy0 - 64'(it.centroid_row);
		for (int i = 0; i < KEEP; i++) begin
			if (kept_valid[i]) begin
				cd[n] = kept_dist[i];
				cl[n] = kept_label[i];
				n++;
			end
		end
		cd[n] = dx * dx + dy * dy;
		cl[n] = it.label;
		n++;
		cap = (max_regions_r < KEEP) ? 64'(max_regions_r) : KEEP;
		while (n > cap) begin
			worst = 0;
			for (int i = 1; i < n; i++)
				if (pair_above(cd[i], cl[i], cd[worst], cl[worst]))
					worst = i;
			if (cl[worst] == it.label)
				in_set = 0;
			cd[worst] = cd[n - 1];
			cl[worst] = cl[n - 1];
			n--;
		end
		clear_kept();
		for (int i = 0; i < n; i++) begin
			kept_dist[i] = cd[i];
			kept_label[i] = cl[i];
			kept_valid[i] = 1;
		end
		return in_set;
	endfunction

	function automatic select_result_t predict_select(region_item_t it);
		select_result_t r;
		int k, cnt;
		r = '{1'b0, 1'b0, '0};
		cnt = 0;
		if (it.act == ACT_CLEAR) begin
			clear_kept();
		end else if (it.act == ACT_OFFER) begin
			r.accepted = offer_region(it);
		end else if (it.act == ACT_QUERY) begin
			k = (it.label == 0) ? -1 : find_kept(it.label);
			if (k >= 0) begin
				for (int i = 0; i < KEEP; i++)
					if (kept_valid[i] && pair_above(kept_dist[i], kept_label[i],
							kept_dist[k], kept_label[k]))
						cnt++;
				r.is_kept = 1'b1;
				r.rank = RANK_W'(cnt);
			end
		end
		return r;
	endfunction

	function automatic int draw_src_gap();
		if ($urandom_range(0, 39) == 0)
			src_quiet = !src_quiet;
		return src_quiet ? 0 : int'($urandom_range(0, 11));
	endfunction

	function automatic int draw_snk_gap();
		if ($urandom_range(0, 39) == 0)
			snk_quiet = !snk_quiet;
		return snk_quiet ? 0 : int'($urandom_range(0, 11));
	endfunction

	// item source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				answer_q.push_back(predict_select(cur_item));
			if (s_tvalid && !s_tready) begin
			end else if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				cur_item <= pending_q[0];
				s_tuser <= pending_q[0].act;
				s_tdata <= S_TDATA_W'({pending_q[0].centroid_row, pending_q[0].centroid_col,
					pending_q[0].region_area, pending_q[0].box_height,
					pending_q[0].box_width, pending_q[0].box_top,
					pending_q[0].box_left, pending_q[0].label});
				void'(pending_q.pop_front());
				s_tvalid <= 1'b1;
				src_gap <= draw_src_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink and checker
	always @(posedge clk or negedge arst_n) begin
		int nxt_wait, nxt_hold;
		select_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_wait <= 0;
			snk_hold <= 0;
		end else begin
			nxt_wait = snk_wait;
			nxt_hold = snk_hold;
			if (m_tvalid && m_tready) begin
				n_results++;
				if (answer_q.size() == 0) begin
					$error("result item with nothing expected");
					fail_count++;
				end else begin
					want = answer_q.pop_front();
					if (m_tdata[0] !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, m_tdata[0]);
						fail_count++;
					end
					if (m_tdata[1] !== want.is_kept) begin
						$error("is_kept: expected %0d, got %0d", want.is_kept, m_tdata[1]);
						fail_count++;
					end
					if (m_tdata[2 +: RANK_W] !== want.rank) begin
						$error("rank: expected %0d, got %0d", want.rank, m_tdata[2 +: RANK_W]);
						fail_count++;
					end
					n_entered += want.accepted;
					n_hits += want.is_kept;
				end
				nxt_wait = draw_snk_gap();
				// long back-pressure so the pipe fills and s_tready drops
				if (n_results % 400 == 150)
					nxt_hold = 300;
			end else if (nxt_hold != 0) begin
				nxt_hold--;
			end else if (nxt_wait != 0) begin
				nxt_wait--;
			end
			snk_wait <= nxt_wait;
			snk_hold <= nxt_hold;
			m_tready <= (nxt_wait == 0 && nxt_hold == 0);
		end
	end

	function automatic int unsigned clamp_coord(int v);
		return (v < 0) ? 0 : (v > int'(COORD_TOP)) ? COORD_TOP : v;
	endfunction

	function automatic logic [CB-1:0] pick_label();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		if (r < 6)
			return CB'(COORD_TOP);
		if (r < 14)
			return CB'($urandom_range(1, COORD_TOP));
		return CB'($urandom_range(1, label_span));
	endfunction

	function automatic region_item_t make_item(logic [ACTION_W-1:0] act, int unsigned lab,
			int unsigned left, int unsigned top, int unsigned bw, int unsigned bh,
			int unsigned area, int unsigned cx, int unsigned cy);
		region_item_t it;
		it.act = act;
		it.label = CB'(lab);
		it.box_left = CB'(left);
		it.box_top = CB'(top);
		it.box_width = DIM_W'(bw);
		it.box_height = DIM_W'(bh);
		it.region_area = AREA_W'(area);
		it.centroid_col = CB'(cx);
		it.centroid_row = CB'(cy);
		return it;
	endfunction

	function automatic region_item_t random_item();
		region_item_t it;
		int unsigned pick, w, h, lo, hi;
		it = make_item(ACT_OFFER, $urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP),
			$urandom_range(0, COORD_TOP), $urandom_range(0, DIM_TOP),
			$urandom_range(0, DIM_TOP), $urandom_range(0, AREA_TOP),
			$urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP));
		w = width_r;
		h = height_r;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			it.act = ACT_CLEAR;
		end else if (pick < 9) begin
			it.act = ACT_SPARE;
		end else if (pick < 38) begin
			it.act = ACT_QUERY;
			it.label = pick_label();
		end else if (pick >= 48 && w >= 2 && h >= 2) begin
			it.label = pick_label();
			it.box_left = CB'($urandom_range(1, w - 1));
			it.box_width = DIM_W'($urandom_range(0, w - 1 - it.box_left));
			it.box_top = CB'($urandom_range(1, h - 1));
			it.box_height = DIM_W'($urandom_range(0, h - 1 - it.box_top));
			lo = min_area_r;
			hi = (lo + 100000 > AREA_TOP) ? AREA_TOP : lo + 100000;
			if (lo == 0)
				it.region_area = AREA_W'($urandom_range(0, 20000));
			else if ($urandom_range(0, 99) < 85)
				it.region_area = AREA_W'($urandom_range(lo, hi));
			else
				it.region_area = AREA_W'($urandom_range(0, lo - 1));
			// near the centre gives many equal distances
			if ($urandom_range(0, 1)) begin
				it.centroid_col = CB'(clamp_coord(int'(w / 2) + int'($urandom_range(0, 8)) - 4));
				it.centroid_row = CB'(clamp_coord(int'(h / 2) + int'($urandom_range(0, 8)) - 4));
			end else begin
				it.centroid_col = CB'($urandom_range(it.box_left,
					clamp_coord(int'(it.box_left) + int'(it.box_width))));
				it.centroid_row = CB'($urandom_range(it.box_top,
					clamp_coord(int'(it.box_top) + int'(it.box_height))));
			end
		end
		return it;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_MIN_AREA: min_area_r = val[AREA_W-1:0];
			CFG_MAX_REGIONS: max_regions_r = val[MAXREG_W-1:0];
			CFG_IMAGE_WIDTH: width_r = val[DIM_W-1:0];
			CFG_IMAGE_HEIGHT: height_r = val[DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || s_tvalid || answer_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned ma, mr, iw, ih, cnt;
		clear_kept();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 640 x 480, min_area 0, three kept, centre (320, 240)
		pending_q.push_back(make_item(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_item(ACT_OFFER, 0, 1, 1, 10, 10, 100, 320, 240));
		pending_q.push_back(make_item(ACT_OFFER, 5, 1, 1, 10, 10, 100, 320, 240));
		pending_q.push_back(make_item(ACT_OFFER, 5, 1, 1, 10, 10, 100, 300, 200));
		pending_q.push_back(make_item(ACT_OFFER, 6, 0, 1, 10, 10, 100, 320, 240));
		pending_q.push_back(make_item(ACT_OFFER, 7, 1, 0, 10, 10, 100, 320, 240));
		pending_q.push_back(make_item(ACT_OFFER, 8, 630, 1, 10, 10, 100, 320, 240));
		pending_q.push_back(make_item(ACT_OFFER, 9, 1, 470, 10, 10, 100, 320, 240));
		pending_q.push_back(make_item(ACT_OFFER, 10, 629, 469, 10, 10, 0, 0, 0));
		pending_q.push_back(make_item(ACT_OFFER, 4095, 1, 1, 0, 0, AREA_TOP, 4095, 4095));
		pending_q.push_back(make_item(ACT_OFFER, 11, 1, 1, 0, 0, 1, 320, 241));
		pending_q.push_back(make_item(ACT_OFFER, 12, 1, 1, 0, 0, 1, 320, 239));
		pending_q.push_back(make_item(ACT_OFFER, 13, 1, 1, 0, 0, 1, 321, 240));
		pending_q.push_back(make_item(ACT_QUERY, 5, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_item(ACT_QUERY, 12, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_item(ACT_QUERY, 11, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_item(ACT_QUERY, 13, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_item(ACT_QUERY, 4095, 4095, 4095, 4096, 4096, AREA_TOP,
			4095, 4095));
		pending_q.push_back(make_item(ACT_SPARE, 5, 4095, 4095, 4096, 4096, AREA_TOP,
			4095, 4095));
		pending_q.push_back(make_item(ACT_OFFER, 14, 1, 1, 4096, 4096, 500, 320, 240));
		pending_q.push_back(make_item(ACT_QUERY, 5, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_item(ACT_CLEAR, 5, 4095, 4095, 4096, 4096, AREA_TOP,
			4095, 4095));
		pending_q.push_back(make_item(ACT_QUERY, 5, 0, 0, 0, 0, 0, 0, 0));
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin ma = 0; mr = 8; iw = 4096; ih = 4096; cnt = 180; end
				1: begin ma = AREA_TOP; mr = 1; iw = 640; ih = 480; cnt = 120; end
				2: begin ma = 100; mr = 3; iw = 640; ih = 480; cnt = 200; end
				3: begin ma = 0; mr = 0; iw = 320; ih = 240; cnt = 100; end
				4: begin ma = 50; mr = 15; iw = 1000; ih = 700; cnt = 200; end
				5: begin ma = 0; mr = 4; iw = 0; ih = 480; cnt = 60; end
				6: begin ma = 20; mr = 8; iw = 2; ih = 2; cnt = 80; end
				7: begin ma = 0; mr = 5; iw = 4096; ih = 1; cnt = 60; end
				default: begin
					ma = $urandom_range(0, 2000);
					mr = $urandom_range(1, 8);
					iw = $urandom_range(16, DIM_TOP);
					ih = $urandom_range(16, DIM_TOP);
					cnt = 200;
				end
			endcase
			write_reg(CFG_MIN_AREA, CFG_DATA_W'(ma));
			write_reg(CFG_MAX_REGIONS, CFG_DATA_W'(mr));
			write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(iw));
			write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(ih));
			n_settings++;
			label_span = $urandom_range(4, 20);
			// two halves; the source waits for every result in between
			for (int half = 0; half < 2; half++) begin
				for (int i = 0; i < cnt / 2; i++)
					pending_q.push_back(random_item());
				drain();
			end
		end

		repeat (10) @(posedge clk);
		if (answer_q.size() != 0) begin
			$error("%0d results never arrived", answer_q.size());
			fail_count++;
		end
		$display("run: %0d result items over %0d register settings after the directed set",
			n_results, n_settings);
		$display("run: %0d regions entered the kept set, %0d queries found a kept label",
			n_entered, n_hits);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
